// File: design/periodic_task_table_scheduler_top_defines.svh
// Assertion macros shared by the periodic task table scheduler RTL.
`ifndef PERIODIC_TASK_TABLE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_TABLE_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define PTTS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptts assertion failed");
// Check that cons holds in the cycle after ante.
`define PTTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptts assertion failed");
`else
`define PTTS_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define PTTS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: design/ptts_pkg.sv
// Types and constants of the periodic task table scheduler.
`default_nettype none

package ptts_pkg;

   localparam int MAX_TASKS   = 8;
   localparam int TIME_BITS   = 16;
   localparam int MAX_RESULTS = 8;
   localparam int PEND_W      = 8;
   localparam int TAG_W       = 8;
   localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W       = $clog2(MAX_TASKS + 1);
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);
   localparam int CMP_W       = (CNT_W > 3) ? CNT_W : 3;

   typedef enum logic [1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_ADD      = 2'd1,
      FUNC_DELETE   = 2'd2,
      FUNC_DISPATCH = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_FULL    = 3'd1,
      ST_NOENTRY = 3'd2,
      ST_RUN     = 3'd3,
      ST_IDLE    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_TICK,
      CELL_LOAD,
      CELL_SHIFT,
      CELL_DEC
   } cell_op_type;

   typedef struct packed {
      logic [TAG_W-1:0]     tag;
      logic [TIME_BITS-1:0] delay;
      logic [TIME_BITS-1:0] period;
      logic [PEND_W-1:0]    pending;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   load;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: design/ptts_cell.sv
// One table slot: holds an entry, ticks it, loads it, or takes its neighbor's.
`default_nettype none

module ptts_cell (
   input  wire logic                clock,
   input  wire ptts_pkg::cell_ctl_type ctl,
   input  wire ptts_pkg::entry_type next_entry,
   output ptts_pkg::entry_type      entry
);

   ptts_pkg::entry_type entry_ff;
   ptts_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         ptts_pkg::CELL_HOLD: begin
            entry_in = entry_ff;
         end
         ptts_pkg::CELL_TICK: begin
            if (entry_ff.delay != '0) begin
               entry_in.delay = entry_ff.delay - 1'b1;
            end else begin
               // reload and count one more run, saturating
               entry_in.delay = entry_ff.period;
               if (entry_ff.pending != {ptts_pkg::PEND_W{1'b1}}) begin
                  entry_in.pending = entry_ff.pending + 1'b1;
               end
            end
         end
         ptts_pkg::CELL_LOAD: begin
            entry_in = ctl.load;
         end
         ptts_pkg::CELL_SHIFT: begin
            entry_in = next_entry;
         end
         ptts_pkg::CELL_DEC: begin
            entry_in.pending = entry_ff.pending - 1'b1;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: design/periodic_task_table_scheduler_top.sv
// Top level of the periodic task table scheduler: cell row and request sequencer.
//
// Usage: drive req_func and its operand ports with start high; the request is
// taken at a rising edge where start is high and busy is low. Tick, add and
// delete finish in the accepting cycle and give one result, with rsp_last set,
// on the rsp_ ports in the next cycle, marked by rsp_valid for one cycle.
// Dispatch raises busy and scans the row of cells one slot per cycle; a
// dispatched slot that is one-shot is removed by shifting the cells above it
// down, and the same slot is examined again in the next cycle. Each result of
// a dispatch appears in the cycle after the cycle that found it, one per
// cycle at most, and rsp_last marks the final one (a lookahead over the cells
// ends the scan as soon as no later slot has pending runs, or at MAX_RESULTS
// results). A dispatch keeps busy high until its last result is found or the
// scan runs out; every scan cycle either advances the cursor or removes a
// slot. A new request can be taken in the cycle after its last result is
// found. Tick updates every cell at once, delete shifts the row at once.
// Results cannot be held off by the receiver. Synchronous reset empties the
// table and drops busy; table contents are not cleared.
`default_nettype none
`include "periodic_task_table_scheduler_top_defines.svh"

module periodic_task_table_scheduler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_task_tag,
   input  wire logic [15:0] req_start_delay,
   input  wire logic [15:0] req_run_period,
   input  wire logic [2:0]  req_task_index,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [2:0]       rsp_entry_index,
   output logic [7:0]       rsp_entry_tag,
   output logic             rsp_last
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DISP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [ptts_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ptts_pkg::CNT_W-1:0] cursor_ff, cursor_in;
   logic [ptts_pkg::RES_W-1:0] nres_ff, nres_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [2:0] rsp_index_ff, rsp_index_in;
   logic [7:0] rsp_tag_ff, rsp_tag_in;
   logic       rsp_last_ff, rsp_last_in;

   ptts_pkg::entry_type    cell_entry [ptts_pkg::MAX_TASKS];
   ptts_pkg::cell_ctl_type cell_ctl   [ptts_pkg::MAX_TASKS];
   ptts_pkg::entry_type    cur_entry;
   ptts_pkg::entry_type    load_entry;
   ptts_pkg::func_type     func;

   logic accept;
   logic full;
   logic del_ok;
   logic later_pending;
   logic at_end;
   logic emit;
   logic remove;
   logic final_res;

   assign busy   = (state_ff == S_DISP);
   assign accept = start && !busy;
   assign func   = ptts_pkg::func_type'(req_func);
   assign full   = (count_ff == ptts_pkg::CNT_W'(ptts_pkg::MAX_TASKS));
   assign del_ok = (ptts_pkg::CMP_W'(req_task_index) < ptts_pkg::CMP_W'(count_ff));

   assign load_entry.tag     = req_task_tag;
   assign load_entry.delay   = ptts_pkg::TIME_BITS'(req_start_delay);
   assign load_entry.period  = ptts_pkg::TIME_BITS'(req_run_period);
   assign load_entry.pending = '0;

   // slot under the scan cursor and lookahead over the slots above it
   assign cur_entry = cell_entry[cursor_ff[ptts_pkg::IDX_W-1:0]];
   assign at_end    = (cursor_ff >= count_ff);
   assign emit      = busy && !at_end && (cur_entry.pending != '0);
   assign remove    = emit && (cur_entry.period == '0);

   always_comb begin
      later_pending = 1'b0;
      for (int j = 0; j < ptts_pkg::MAX_TASKS; j++) begin
         if (ptts_pkg::CNT_W'(j) > cursor_ff && ptts_pkg::CNT_W'(j) < count_ff &&
             cell_entry[j].pending != '0) begin
            later_pending = 1'b1;
         end
      end
   end

   assign final_res = (nres_ff == ptts_pkg::RES_W'(ptts_pkg::MAX_RESULTS - 1)) ||
                      !later_pending;

   // per-cell commands
   always_comb begin
      for (int j = 0; j < ptts_pkg::MAX_TASKS; j++) begin
         cell_ctl[j].op   = ptts_pkg::CELL_HOLD;
         cell_ctl[j].load = load_entry;
         if (accept) begin
            unique case (func)
               ptts_pkg::FUNC_TICK: begin
                  cell_ctl[j].op = ptts_pkg::CELL_TICK;
               end
               ptts_pkg::FUNC_ADD: begin
                  if (!full && ptts_pkg::CNT_W'(j) == count_ff) begin
                     cell_ctl[j].op = ptts_pkg::CELL_LOAD;
                  end
               end
               ptts_pkg::FUNC_DELETE: begin
                  if (del_ok && ptts_pkg::CMP_W'(j) >= ptts_pkg::CMP_W'(req_task_index)) begin
                     cell_ctl[j].op = ptts_pkg::CELL_SHIFT;
                  end
               end
               ptts_pkg::FUNC_DISPATCH: begin
                  cell_ctl[j].op = ptts_pkg::CELL_HOLD;
               end
               default: begin
                  cell_ctl[j].op = ptts_pkg::CELL_HOLD;
               end
            endcase
         end else if (emit) begin
            if (remove && ptts_pkg::CNT_W'(j) >= cursor_ff) begin
               cell_ctl[j].op = ptts_pkg::CELL_SHIFT;
            end else if (ptts_pkg::CNT_W'(j) == cursor_ff) begin
               cell_ctl[j].op = ptts_pkg::CELL_DEC;
            end
         end
      end
   end

   for (genvar g = 0; g < ptts_pkg::MAX_TASKS; g++) begin : g_cell
      ptts_pkg::entry_type nbr;
      if (g == ptts_pkg::MAX_TASKS - 1) begin : g_top
         assign nbr = cell_entry[g];
      end else begin : g_mid
         assign nbr = cell_entry[g + 1];
      end
      ptts_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .next_entry (nbr),
         .entry      (cell_entry[g])
      );
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      nres_in       = nres_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ptts_pkg::ST_DONE;
      rsp_index_in  = '0;
      rsp_tag_in    = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (func)
                  ptts_pkg::FUNC_TICK: begin
                     rsp_valid_in = 1'b1;
                  end
                  ptts_pkg::FUNC_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = ptts_pkg::ST_FULL;
                     end else begin
                        rsp_index_in = 3'(count_ff);
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  ptts_pkg::FUNC_DELETE: begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = req_task_index;
                     if (del_ok) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = ptts_pkg::ST_NOENTRY;
                     end
                  end
                  ptts_pkg::FUNC_DISPATCH: begin
                     state_in  = S_DISP;
                     cursor_in = '0;
                     nres_in   = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_DISP: begin
            if (at_end) begin
               // scan ran out without a single run
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptts_pkg::ST_IDLE;
               state_in      = S_IDLE;
            end else if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptts_pkg::ST_RUN;
               rsp_index_in  = 3'(cursor_ff);
               rsp_tag_in    = cur_entry.tag;
               rsp_last_in   = final_res;
               if (remove) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  cursor_in = cursor_ff + 1'b1;
               end
               if (final_res) begin
                  state_in = S_IDLE;
               end else begin
                  nres_in = nres_ff + 1'b1;
               end
            end else begin
               cursor_in = cursor_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         nres_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         nres_ff      <= nres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_tag   = rsp_tag_ff;
   assign rsp_last        = rsp_last_ff;

   `PTTS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
                      count_ff <= ptts_pkg::CNT_W'(ptts_pkg::MAX_TASKS))
   `PTTS_ASSERT_NEXT(a_disp_enter, clock, reset,
                     accept && func == ptts_pkg::FUNC_DISPATCH, state_ff == S_DISP)
   `PTTS_ASSERT_NEXT(a_disp_no_grow, clock, reset, state_ff == S_DISP,
                     count_ff <= $past(count_ff))
   `PTTS_ASSERT_IMPLY(a_idle_only_first, clock, reset, busy && at_end,
                      nres_ff == '0)
   `PTTS_ASSERT_IMPLY(a_res_bound, clock, reset, 1'b1,
                      nres_ff < ptts_pkg::RES_W'(ptts_pkg::MAX_RESULTS))

endmodule

`default_nettype wire

// File: sim/ptts_checker.sv
// Checker for the periodic task table scheduler: watches both channels, predicts and compares.
`default_nettype none

module ptts_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_task_tag,
   input  wire logic [15:0] req_start_delay,
   input  wire logic [15:0] req_run_period,
   input  wire logic [2:0]  req_task_index,
   input  wire logic        rsp_valid,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [2:0]  rsp_entry_index,
   input  wire logic [7:0]  rsp_entry_tag,
   input  wire logic        rsp_last,
   output int               mismatches,
   output int               outstanding,
   output int               accepted,
   output int               checked
);

   typedef struct packed {
      ptts_pkg::status_type status;
      logic [2:0] index;
      logic [7:0] tag;
      logic       last;
   } outcome_type;

   outcome_type due_results[$];
   outcome_type oldest;

   // shadow copy of the task table
   logic [3:0]  live_count;
   logic [7:0]  tag_row     [ptts_pkg::MAX_TASKS];
   logic [15:0] delay_row   [ptts_pkg::MAX_TASKS];
   logic [15:0] period_row  [ptts_pkg::MAX_TASKS];
   logic [7:0]  pending_row [ptts_pkg::MAX_TASKS];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      accepted    = 0;
      checked     = 0;
      live_count  = '0;
   end

   function automatic outcome_type outcome(ptts_pkg::status_type s, int index,
                                           logic [7:0] tag, logic last);
      outcome_type o;
      o.status = s;
      o.index  = 3'(index);
      o.tag    = tag;
      o.last   = last;
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
      mismatches++;
   endtask

   // remove one entry and close the gap
   task automatic drop_entry(int pos);
      int k;
      for (k = pos; k + 1 < live_count; k++) begin
         tag_row[k]     = tag_row[k+1];
         delay_row[k]   = delay_row[k+1];
         period_row[k]  = period_row[k+1];
         pending_row[k] = pending_row[k+1];
      end
      live_count--;
   endtask

   task automatic schedule_request(ptts_pkg::func_type f, logic [7:0] tag,
                                   logic [15:0] dly, logic [15:0] per, logic [2:0] idx);
      outcome_type found [ptts_pkg::MAX_RESULTS];
      int slot;
      int n;
      n = 0;
      unique case (f)
         ptts_pkg::FUNC_TICK: begin
            for (slot = 0; slot < live_count; slot++) begin
               if (delay_row[slot] != 16'd0) begin
                  delay_row[slot]--;
               end else begin
                  delay_row[slot] = period_row[slot];
                  if (pending_row[slot] != 8'hFF) pending_row[slot]++;
               end
            end
            due_results.push_back(outcome(ptts_pkg::ST_DONE, 0, 8'd0, 1'b1));
         end
         ptts_pkg::FUNC_ADD: begin
            if (live_count >= ptts_pkg::MAX_TASKS) begin
               due_results.push_back(outcome(ptts_pkg::ST_FULL, 0, 8'd0, 1'b1));
            end else begin
               tag_row[live_count]     = tag;
               delay_row[live_count]   = dly;
               period_row[live_count]  = per;
               pending_row[live_count] = 8'd0;
               due_results.push_back(outcome(ptts_pkg::ST_DONE, live_count, 8'd0, 1'b1));
               live_count++;
            end
         end
         ptts_pkg::FUNC_DELETE: begin
            if (idx >= live_count) begin
               due_results.push_back(outcome(ptts_pkg::ST_NOENTRY, idx, 8'd0, 1'b1));
            end else begin
               drop_entry(idx);
               due_results.push_back(outcome(ptts_pkg::ST_DONE, idx, 8'd0, 1'b1));
            end
         end
         default: begin
            slot = 0;
            while (slot < live_count && n < ptts_pkg::MAX_RESULTS) begin
               if (pending_row[slot] != 8'd0) begin
                  pending_row[slot]--;
                  found[n] = outcome(ptts_pkg::ST_RUN, slot, tag_row[slot], 1'b0);
                  n++;
                  // one-shot: the entry shifted into this slot is examined next
                  if (period_row[slot] == 16'd0) begin
                     drop_entry(slot);
                     continue;
                  end
               end
               slot++;
            end
            if (n == 0) begin
               due_results.push_back(outcome(ptts_pkg::ST_IDLE, 0, 8'd0, 1'b1));
            end else begin
               found[n-1].last = 1'b1;
               for (slot = 0; slot < n; slot++) due_results.push_back(found[slot]);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         live_count = '0;
         due_results.delete();
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (due_results.size() == 0) begin
               report_mismatch("result with none due, status", rsp_status, -1);
            end else begin
               oldest = due_results.pop_front();
               if (rsp_valid !== 1'b1)
                  report_mismatch("valid strobe", rsp_valid, 1);
               if (rsp_status !== oldest.status)
                  report_mismatch("status", rsp_status, oldest.status);
               if (rsp_entry_index !== oldest.index)
                  report_mismatch("entry index", rsp_entry_index, oldest.index);
               if (rsp_entry_tag !== oldest.tag)
                  report_mismatch("entry tag", rsp_entry_tag, oldest.tag);
               if (rsp_last !== oldest.last)
                  report_mismatch("last flag", rsp_last, oldest.last);
               checked++;
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            accepted++;
            schedule_request(ptts_pkg::func_type'(req_func), req_task_tag, req_start_delay,
                             req_run_period, req_task_index);
         end
      end
      outstanding = due_results.size();
   end

endmodule

`default_nettype wire

// File: sim/periodic_task_table_scheduler_top_tb.sv
// Testbench top for the periodic task table scheduler: stimulus and verdict.
`default_nettype none

module periodic_task_table_scheduler_top_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = 2'd0;
   logic [7:0]  req_task_tag = 8'd0;
   logic [15:0] req_start_delay = 16'd0;
   logic [15:0] req_run_period = 16'd0;
   logic [2:0]  req_task_index = 3'd0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_entry_index;
   logic [7:0]  rsp_entry_tag;
   logic        rsp_last;

   int mismatches;
   int outstanding;
   int accepted;
   int checked;
   int issued = 0;
   int sender_idle_pct = 0;

   always #1 clock = ~clock;

   periodic_task_table_scheduler_top uut (
      .clock, .reset, .start, .busy,
      .req_func, .req_task_tag, .req_start_delay, .req_run_period, .req_task_index,
      .rsp_valid, .rsp_status, .rsp_entry_index, .rsp_entry_tag, .rsp_last
   );

   ptts_checker table_watch (
      .clock, .reset, .start, .busy,
      .req_func, .req_task_tag, .req_start_delay, .req_run_period, .req_task_index,
      .rsp_valid, .rsp_status, .rsp_entry_index, .rsp_entry_tag, .rsp_last,
      .mismatches, .outstanding, .accepted, .checked
   );

   initial begin
      #2000000;
      $display("timeout");
      $display("periodic_task_table_scheduler_top_tb NOT OK");
      $finish;
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(ptts_pkg::func_type f, logic [7:0] tag, logic [15:0] dly,
                               logic [15:0] per, logic [2:0] idx);
      while ($urandom_range(99) < sender_idle_pct) begin
         start           <= 1'b0;
         req_func        <= 2'($urandom_range(3));
         req_task_tag    <= 8'($urandom);
         req_start_delay <= 16'($urandom);
         req_run_period  <= 16'($urandom);
         req_task_index  <= 3'($urandom);
         @(negedge clock);
      end
      start           <= 1'b1;
      req_func        <= f;
      req_task_tag    <= tag;
      req_start_delay <= dly;
      req_run_period  <= per;
      req_task_index  <= idx;
      issued++;
      do @(negedge clock); while (accepted != issued);
   endtask

   // hold off until every due result has come
   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic send_random_request();
      ptts_pkg::func_type f;
      logic [15:0]        dly;
      logic [15:0]        per;
      int                 pick;
      pick = $urandom_range(99);
      f = (pick < 40) ? ptts_pkg::FUNC_TICK : (pick < 62) ? ptts_pkg::FUNC_ADD :
          (pick < 74) ? ptts_pkg::FUNC_DELETE : ptts_pkg::FUNC_DISPATCH;
      // keep most delays short so entries become ready
      dly = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      pick = $urandom_range(9);
      per = (pick < 3) ? 16'd0 : (pick < 9) ? 16'($urandom_range(5, 1)) : 16'($urandom);
      send_request(f, 8'($urandom_range(255)), dly, per, 3'($urandom_range(7)));
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table
      send_request(ptts_pkg::FUNC_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_TICK, 8'd0, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_DELETE, 8'd0, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_DELETE, 8'd0, 16'd0, 16'd0, 3'd7);
      // fill the table, then overflow it
      send_request(ptts_pkg::FUNC_ADD, 8'h00, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
      send_request(ptts_pkg::FUNC_ADD, 8'hA5, 16'd0, 16'd1, 3'd0);
      send_request(ptts_pkg::FUNC_ADD, 8'h5A, 16'd1, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_ADD, 8'h3C, 16'd0, 16'd2, 3'd0);
      send_request(ptts_pkg::FUNC_ADD, 8'hC3, 16'd2, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_ADD, 8'h81, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_ADD, 8'h7E, 16'h5555, 16'hAAAA, 3'd0);
      send_request(ptts_pkg::FUNC_ADD, 8'h11, 16'd0, 16'd0, 3'd0);
      // delete last, past the end, and from the middle
      send_request(ptts_pkg::FUNC_DELETE, 8'd0, 16'd0, 16'd0, 3'd7);
      send_request(ptts_pkg::FUNC_DELETE, 8'd0, 16'd0, 16'd0, 3'd7);
      send_request(ptts_pkg::FUNC_DELETE, 8'd0, 16'd0, 16'd0, 3'd1);
      repeat (3) send_request(ptts_pkg::FUNC_TICK, 8'd0, 16'd0, 16'd0, 3'd0);
      // back-to-back one-shots removed within one dispatch
      send_request(ptts_pkg::FUNC_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_TICK, 8'd0, 16'd0, 16'd0, 3'd0);
      send_request(ptts_pkg::FUNC_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0);

      sender_idle_pct = 26;
      repeat (28) send_random_request();
      wait_drained();
      sender_idle_pct = 85;
      repeat (28) send_random_request();
      sender_idle_pct = 0;
      repeat (28) send_random_request();

      wait_drained();
      repeat (40) @(negedge clock);
      $display("requests accepted: %0d, results checked: %0d", accepted, checked);
      $display("covered empty/full table, bad deletes, one-shot removal, random traffic");
      if (mismatches == 0) begin
         $display("periodic_task_table_scheduler_top_tb OK");
      end else begin
         $display("periodic_task_table_scheduler_top_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/ptts_pkg.sv
design/ptts_cell.sv
design/periodic_task_table_scheduler_top.sv
sim/ptts_checker.sv
sim/periodic_task_table_scheduler_top_tb.sv
